### hw/rtl/substring_match_counter_macros.svh
// ----------------------------------------------------------------------------
// substring_match_counter_macros
// Assertion macros used by the checker of the substring match counter.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_COUNTER_MACROS_SVH
`define SUBSTRING_MATCH_COUNTER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("substring_match_counter check failed");

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("substring_match_counter check failed");

`endif

### hw/rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Types and constants of the substring match counter.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

    localparam int NEEDLE_BYTES = 16;
    localparam int LEN_W        = 5;
    localparam int COUNT_W      = 16;
    localparam int OUT_POS_W    = 16;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REG_NEEDLE_LOW  = 2'd0,
        REG_NEEDLE_HIGH = 2'd1,
        REG_NEEDLE_LEN  = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

### hw/rtl/substring_match_counter.sv
// ----------------------------------------------------------------------------
// substring_match_counter
// Streaming substring search: counts non-overlapping needle matches per text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one text byte per beat,
//   with i_end_of_text on the last byte of a text. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result beat per input beat.
//   Each result is registered: a byte accepted at one edge has its result on the
//   outputs right after it. Throughput is one byte per cycle unless the receiver
//   stalls; all needle byte compares of the window run in parallel between the
//   state registers and the result register.
//   When the receiver stalls with a result held, o_in_stall rises in the same
//   cycle and the held result stays unchanged until taken.
//   The needle is set through the APB port (64-bit data, registers at byte
//   addresses 0, 8, 16); write it only while the block is idle.
//   Synchronous reset clears the output valid flag, the per-text state and
//   the needle registers (length 1, bytes zero). The result of the last byte
//   of a text also clears the per-text state for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_match_counter
    import smc_pkg::*;
#(
    parameter int NEEDLE_MAX     = 16,
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_end_of_text,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_match_here,
    output logic [OUT_POS_W-1:0]      o_match_start,
    output logic [COUNT_W-1:0]        o_match_count,
    output logic                      o_found_any,
    output logic [OUT_POS_W-1:0]      o_first_start,
    output logic                      o_text_done,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic                      pready
);

    localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    logic [DATA_W-1:0] r_needle_low;
    logic [DATA_W-1:0] r_needle_high;
    logic [LEN_W-1:0]  r_needle_len;

    logic [7:0]                r_recent [NEEDLE_MAX];
    logic [LEN_W-1:0]          r_depth;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_found;
    logic [POSITION_WIDTH-1:0] r_first_pos;

    logic                      r_out_valid;
    logic                      r_match_here;
    logic [OUT_POS_W-1:0]      r_match_start;
    logic [COUNT_W-1:0]        r_match_count;
    logic                      r_found_any;
    logic [OUT_POS_W-1:0]      r_first_start;
    logic                      r_text_done;

    logic                      in_accept;
    logic                      cfg_write;
    logic [2*DATA_W-1:0]       needle;
    logic [LEN_W-1:0]          len;
    logic [7:0]                window [NEEDLE_MAX];
    logic                      hit;
    logic                      depth_ok;
    logic [POSITION_WIDTH-1:0] start;
    logic [LEN_W-1:0]          n_depth;
    logic [POSITION_WIDTH-1:0] n_pos;
    logic [COUNT_W-1:0]        n_count;
    logic                      n_found;
    logic [POSITION_WIDTH-1:0] n_first_pos;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= LEN_W'(1);
        end else if (cfg_write) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_NEEDLE_LOW:  r_needle_low  <= pwdata;
                REG_NEEDLE_HIGH: r_needle_high <= pwdata;
                REG_NEEDLE_LEN:  r_needle_len  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_NEEDLE_LOW:  prdata = r_needle_low;
            REG_NEEDLE_HIGH: prdata = r_needle_high;
            REG_NEEDLE_LEN:  prdata = DATA_W'(r_needle_len);
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // match logic
    assign needle = {r_needle_high, r_needle_low};

    always_comb begin
        if (r_needle_len == '0) begin
            len = LEN_W'(1);
        end else if (r_needle_len > LEN_W'(NEEDLE_MAX)) begin
            len = LEN_W'(NEEDLE_MAX);
        end else begin
            len = r_needle_len;
        end
    end

    always_comb begin
        window[0] = i_text_byte;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            window[k] = r_recent[k-1];
        end
    end

    assign depth_ok = ({1'b0, r_depth} + (LEN_W+1)'(1)) >= {1'b0, len};

    always_comb begin
        logic [LEN_W-1:0] idx;
        hit = depth_ok;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            idx = len - LEN_W'(i) - LEN_W'(1);
            if (LEN_W'(i) < len) begin
                if (window[idx[IDX_W-1:0]] != needle[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign start = r_pos - POSITION_WIDTH'(len - LEN_W'(1));

    always_comb begin
        n_count     = r_count;
        n_found     = r_found;
        n_first_pos = r_first_pos;
        n_depth     = r_depth;
        if (hit) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
            if (!r_found) begin
                n_found     = 1'b1;
                n_first_pos = start;
            end
            n_depth = '0;
        end else if (r_depth < LEN_W'(NEEDLE_MAX)) begin
            n_depth = r_depth + LEN_W'(1);
        end
        n_pos = (r_pos != POS_MAX) ? r_pos + POSITION_WIDTH'(1) : r_pos;
    end

    // per-text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NEEDLE_MAX; k++) begin
                r_recent[k] <= '0;
            end
            r_depth     <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_first_pos <= '0;
        end else if (in_accept) begin
            if (i_end_of_text) begin
                for (int k = 0; k < NEEDLE_MAX; k++) begin
                    r_recent[k] <= '0;
                end
                r_depth     <= '0;
                r_pos       <= '0;
                r_count     <= '0;
                r_found     <= 1'b0;
                r_first_pos <= '0;
            end else begin
                for (int k = 0; k < NEEDLE_MAX; k++) begin
                    r_recent[k] <= window[k];
                end
                r_depth     <= n_depth;
                r_pos       <= n_pos;
                r_count     <= n_count;
                r_found     <= n_found;
                r_first_pos <= n_first_pos;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_match_here  <= hit;
            r_match_start <= hit ? OUT_POS_W'(start) : '0;
            r_match_count <= n_count;
            r_found_any   <= n_found;
            r_first_start <= n_found ? OUT_POS_W'(n_first_pos) : '0;
            r_text_done   <= i_end_of_text;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_here  = r_match_here;
    assign o_match_start = r_match_start;
    assign o_match_count = r_match_count;
    assign o_found_any   = r_found_any;
    assign o_first_start = r_first_start;
    assign o_text_done   = r_text_done;

endmodule

`default_nettype wire

### hw/rtl/smc_checker.sv
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks of the substring match counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_match_counter_macros.svh"

module smc_checker
    import smc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic                 o_match_here,
    input wire logic [OUT_POS_W-1:0] o_match_start,
    input wire logic [COUNT_W-1:0]   o_match_count,
    input wire logic                 o_found_any,
    input wire logic [OUT_POS_W-1:0] o_first_start
);

    `SMC_ASSERT_NEXT(a_held_result, o_out_valid && i_out_stall, o_out_valid && $stable(o_match_count) && $stable(o_match_start))

    `SMC_ASSERT_SAME(a_stall_only_when_full, o_in_stall, o_out_valid && i_out_stall)

    `SMC_ASSERT_SAME(a_no_match_no_start, o_out_valid && !o_match_here, o_match_start == '0)

    `SMC_ASSERT_SAME(a_match_counted, o_out_valid && o_match_here, o_found_any && (o_match_count != '0))

    `SMC_ASSERT_SAME(a_none_found, o_out_valid && !o_found_any, (o_match_count == '0) && (o_first_start == '0))

endmodule

bind substring_match_counter smc_checker u_smc_checker (.*);

`default_nettype wire

### verif/match_result_checker.sv
// ----------------------------------------------------------------------------
// match_result_checker
// Watches the text, result and register ports of the substring match counter,
// keeps its own copy of the needle and per-text match state, predicts the
// result of every accepted text beat and compares each accepted result beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module match_result_checker
    import smc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_end_of_text,

    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_match_here,
    input  wire logic [OUT_POS_W-1:0] i_match_start,
    input  wire logic [COUNT_W-1:0]   i_match_count,
    input  wire logic                 i_found_any,
    input  wire logic [OUT_POS_W-1:0] i_first_start,
    input  wire logic                 i_text_done,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    input  wire logic                 pready,

    output int unsigned               o_error_count,
    output int unsigned               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 100;
    localparam logic [OUT_POS_W-1:0] POS_LIMIT = '1;

    typedef struct packed {
        logic                 match_here;
        logic [OUT_POS_W-1:0] match_start;
        logic [COUNT_W-1:0]   match_count;
        logic                 found_any;
        logic [OUT_POS_W-1:0] first_start;
        logic                 text_done;
    } t_match_result;

    logic [NEEDLE_BYTES*8-1:0] needle     = '0;
    logic [LEN_W-1:0]          needle_len = LEN_W'(1);

    logic [7:0]           window [NEEDLE_BYTES];
    logic [LEN_W-1:0]     run_depth;
    logic [OUT_POS_W-1:0] next_pos;
    logic [COUNT_W-1:0]   hit_count;
    logic                 seen_hit;
    logic [OUT_POS_W-1:0] first_pos;

    t_match_result awaited_results [$];
    int unsigned   mismatches   = 0;
    int unsigned   result_beats = 0;

    function automatic void clear_text();
        for (int i = 0; i < NEEDLE_BYTES; i++) window[i] = '0;
        run_depth = '0;
        next_pos  = '0;
        hit_count = '0;
        seen_hit  = 1'b0;
        first_pos = '0;
    endfunction

    function automatic t_match_result scan_byte(input logic [7:0] b, input logic is_last);
        t_match_result        r;
        int                   len;
        logic                 hit;
        logic [OUT_POS_W-1:0] start;
        len = int'(needle_len);
        if (len == 0) len = 1;
        if (len > NEEDLE_BYTES) len = NEEDLE_BYTES;
        for (int i = NEEDLE_BYTES - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        hit = (int'(run_depth) + 1 >= len);
        for (int i = 0; i < len; i++) begin
            if (window[len-1-i] != needle[8*i +: 8]) hit = 1'b0;
        end
        start = '0;
        if (hit) begin
            start = next_pos - OUT_POS_W'(len - 1);
            if (hit_count != COUNT_MAX) hit_count++;
            if (!seen_hit) begin
                seen_hit  = 1'b1;
                first_pos = start;
            end
            run_depth = '0;
        end else if (run_depth < NEEDLE_BYTES) begin
            run_depth++;
        end
        if (next_pos != POS_LIMIT) next_pos++;
        r.match_here  = hit;
        r.match_start = start;
        r.match_count = hit_count;
        r.found_any   = seen_hit;
        r.first_start = first_pos;
        r.text_done   = is_last;
        if (is_last) clear_text();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d: %s is %0h, expected %0h",
                                      result_beats, field, got, want));
    endtask

    always @(posedge i_clk) begin
        t_match_result got;
        t_match_result want;
        if (!i_rst_n) begin
            needle     = '0;
            needle_len = LEN_W'(1);
            clear_text();
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:3]))
                    REG_NEEDLE_LOW:  needle[63:0]   = pwdata;
                    REG_NEEDLE_HIGH: needle[127:64] = pwdata;
                    REG_NEEDLE_LEN:  needle_len     = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(scan_byte(i_text_byte, i_end_of_text));
            if (i_out_valid && !i_out_stall) begin
                got = {i_match_here, i_match_start, i_match_count,
                       i_found_any, i_first_start, i_text_done};
                result_beats++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              result_beats));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("match_here",  got.match_here,  want.match_here);
                    compare_field("match_start", got.match_start, want.match_start);
                    compare_field("match_count", got.match_count, want.match_count);
                    compare_field("found_any",   got.found_any,   want.found_any);
                    compare_field("first_start", got.first_start, want.first_start);
                    compare_field("text_done",   got.text_done,   want.text_done);
                end
            end
        end
        o_pending     <= awaited_results.size();
        o_error_count <= mismatches;
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text beats and needle settings into the substring match counter:
// a few directed texts, random texts built from needle pieces over many
// needle settings, then one longer text sent back to back.
// Both channels idle and stall in random bursts. The checker predicts and
// compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
    import smc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LONG_TEXT       = 200;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(24);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 in_valid    = 1'b0;
    logic [7:0]           text_byte   = '0;
    logic                 end_of_text = 1'b0;
    logic                 out_stall   = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;

    wire logic                 in_stall;
    wire logic                 out_valid;
    wire logic                 match_here;
    wire logic [OUT_POS_W-1:0] match_start;
    wire logic [COUNT_W-1:0]   match_count;
    wire logic                 found_any;
    wire logic [OUT_POS_W-1:0] first_start;
    wire logic                 text_done;
    wire logic [DATA_W-1:0]    prdata;
    wire logic                 pready;

    int unsigned error_count;
    int unsigned pending;
    int          cycle_count = 0;
    int          stall_left  = 0;
    logic        stall_on    = 1'b0;
    logic        idle_on     = 1'b0;

    logic [NEEDLE_BYTES*8-1:0] needle_cur = '0;
    logic [7:0]                text_q [$];

    substring_match_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_text_byte   (text_byte),
        .i_end_of_text (end_of_text),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_match_here  (match_here),
        .o_match_start (match_start),
        .o_match_count (match_count),
        .o_found_any   (found_any),
        .o_first_start (first_start),
        .o_text_done   (text_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    match_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_text_byte   (text_byte),
        .i_end_of_text (end_of_text),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_match_here  (match_here),
        .i_match_start (match_start),
        .i_match_count (match_count),
        .i_found_any   (found_any),
        .i_first_start (first_start),
        .i_text_done   (text_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16);
            out_stall  <= 1'b1;
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_needle(input logic [NEEDLE_BYTES*8-1:0] bytes, input logic [LEN_W-1:0] len);
        needle_cur = bytes;
        apb_write(ADDR_W'(8 * REG_NEEDLE_LOW),  bytes[63:0]);
        apb_write(ADDR_W'(8 * REG_NEEDLE_HIGH), bytes[127:64]);
        apb_write(ADDR_W'(8 * REG_NEEDLE_LEN),  DATA_W'(len));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= is_last;
        do @(posedge i_clk); while (!(in_valid && !in_stall));
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [NEEDLE_BYTES*8-1:0] nb;
        logic [LEN_W-1:0]          len;
        logic                      alpha;
        int                        eff;
        int                        items;
        int                        target;
        int                        cut;
        int                        pick;
        logic [7:0]                flip;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        stall_on <= 1'b1;

        // reset needle is a single zero byte
        text_q = '{8'h00, 8'h01, 8'h00};
        send_text();
        wait_idle();

        // restart after a partial match must still see the overlap
        set_needle(128'h626161, LEN_W'(3));
        text_q = '{8'h61, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h62};
        send_text();
        wait_idle();

        // matches never overlap
        set_needle(128'h6161, LEN_W'(2));
        text_q = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
        send_text();
        wait_idle();

        // zero length acts as one; write past the register list is dropped
        set_needle(128'hFF, LEN_W'(0));
        apb_write(ADDR_UNMAPPED, {$urandom, $urandom});
        text_q = '{8'hFF, 8'h00, 8'hFF};
        send_text();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       len = LEN_W'(1);
                1:       len = LEN_W'(16);
                2:       len = LEN_W'(31);
                3:       len = LEN_W'(0);
                default: len = LEN_W'($urandom_range(1, 16));
            endcase
            alpha = ($urandom_range(0, 1) == 1);
            for (int i = 0; i < NEEDLE_BYTES; i++)
                nb[8*i +: 8] = alpha ? 8'h61 + 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
            if (ph == 4) nb = '1;
            if (ph == 5) nb = '0;
            set_needle(nb, len);
            eff = (len == 0) ? 1 : (len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(len);

            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                text_q.delete();
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 40);
                while (text_q.size() < target) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        for (int i = 0; i < eff; i++) text_q.push_back(needle_cur[8*i +: 8]);
                    end else if (pick < 7) begin
                        // broken copy: prefix, then one wrong byte
                        cut = $urandom_range(0, eff - 1);
                        for (int i = 0; i < cut; i++) text_q.push_back(needle_cur[8*i +: 8]);
                        flip = 8'h01 << $urandom_range(0, 7);
                        text_q.push_back(needle_cur[8*cut +: 8] ^ flip);
                    end else if (pick < 9) begin
                        text_q.push_back(needle_cur[8*$urandom_range(0, eff - 1) +: 8]);
                    end else begin
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
                idle_on = ($urandom_range(0, 3) != 0);
                stall_on <= ($urandom_range(0, 3) != 0);
                send_text();
                items += text_q.size();
            end
        end

        // longer text back to back, then a short one follows
        wait_idle();
        idle_on = 1'b0;
        stall_on <= 1'b0;
        set_needle(128'h5A, LEN_W'(1));
        for (int i = 0; i < LONG_TEXT; i++)
            send_byte((i % 50 == 49) ? 8'hA5 : 8'h5A, i == LONG_TEXT - 1);
        text_q = '{8'h5A, 8'hA5, 8'h5A};
        send_text();
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
